// ===== sv/usart_pkg.sv =====
// ----------------------------------------------------------------------------
// usart_pkg
// shared types, codes and the character time table of the async usart core
// ----------------------------------------------------------------------------
package usart_pkg;

  localparam int FUNC_W  = 3;
  localparam int TXCNT_W = 19;
  localparam int POLL_W  = 32;
  localparam int CALC_W  = 34;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [TXCNT_W-1:0] txcnt_t;
  typedef logic [1:0]         phase_t;
  typedef logic [6:0]         status_t;

  localparam func_t FN_DATA_RD = 3'd0;
  localparam func_t FN_DATA_WR = 3'd1;
  localparam func_t FN_STAT_RD = 3'd2;
  localparam func_t FN_CTRL_WR = 3'd3;
  localparam func_t FN_TICK    = 3'd4;

  localparam phase_t PH_MODE  = 2'd0;
  localparam phase_t PH_SYNC1 = 2'd1;
  localparam phase_t PH_SYNC2 = 2'd2;
  localparam phase_t PH_CMD   = 2'd3;

  localparam int SB_TXRDY  = 0;
  localparam int SB_RXRDY  = 1;
  localparam int SB_TXE    = 2;
  localparam int SB_PE     = 3;
  localparam int SB_OE     = 4;
  localparam int SB_FE     = 5;
  localparam int SB_SYNDET = 6;

  localparam status_t STATUS_RESET = 7'h05;

  localparam logic [1:0] RF_X1  = 2'd1;
  localparam logic [1:0] RF_X16 = 2'd2;
  localparam logic [1:0] RF_X64 = 2'd3;

  localparam logic [2:0] DIV_MAX = 3'd4;

  // cpu cycles per 10-bit character, by clamped divider and rate factor
  function automatic txcnt_t char_period(input logic [2:0] div, input logic [1:0] rf);
    logic [2:0] d;
    txcnt_t     c;
    d = (div > DIV_MAX) ? DIV_MAX : div;
    c = txcnt_t'(319);
    case (rf)
      RF_X16: begin
        case (d)
          3'd0:    c = txcnt_t'(5119);
          3'd1:    c = txcnt_t'(10239);
          3'd2:    c = txcnt_t'(20479);
          3'd3:    c = txcnt_t'(40958);
          default: c = txcnt_t'(81916);
        endcase
      end
      RF_X64: begin
        case (d)
          3'd0:    c = txcnt_t'(20479);
          3'd1:    c = txcnt_t'(40958);
          3'd2:    c = txcnt_t'(81916);
          3'd3:    c = txcnt_t'(163833);
          default: c = txcnt_t'(327666);
        endcase
      end
      default: begin
        case (d)
          3'd0:    c = txcnt_t'(319);
          3'd1:    c = txcnt_t'(639);
          3'd2:    c = txcnt_t'(1279);
          3'd3:    c = txcnt_t'(2559);
          default: c = txcnt_t'(5119);
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ===== sv/usart_8251_async_core_unit.sv =====
// ----------------------------------------------------------------------------
// usart_8251_async_core_unit
// register-level 8251-style usart: bus accesses, transmit timer and line poll
// ----------------------------------------------------------------------------
// Each input transfer carries one bus access (data read, data write, status
// read, control write) or a tick with an elapsed cycle count and the receive
// and modem line levels. Every input transfer yields exactly one output
// transfer with the read byte, a transmitted byte if one finished, and the
// txrdy, rxrdy, rts and dtr levels after the access.
// The item is captured in an input register and the whole update runs
// combinationally between it and the output register that drives out_valid;
// one item per cycle is sustained while out_stall is low. The item
// path is limited by the 34-bit poll countdown add and compare.
// A new item is taken while a result waits in the output register; in_stall
// rises only when both registers are full and out_stall is high.
// The user writes the baud divider over the cfg_ APB port only while the
// block is idle; the block does not enforce it. Reset clears both registers
// and returns all state to its power-up values; command bit 6 resets the
// programming state but keeps the data bytes, the modem levels and the divider.
// ----------------------------------------------------------------------------
module usart_8251_async_core_unit
  import usart_pkg::*;
#(
  parameter int POLL_PERIOD = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_wr_data,
  input  logic [15:0] in_tick_cycles,
  input  logic        in_rx_present,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_cts_in,
  input  logic        in_dsr_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_txrdy,
  output logic        out_rxrdy,
  output logic        out_rx_taken,
  output logic        out_rts_out,
  output logic        out_dtr_out,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic signed [POLL_W-1:0] POLL_RST = POLL_W'(POLL_PERIOD);
  localparam logic signed [CALC_W-1:0] POLL_ADD = CALC_W'(POLL_PERIOD);
  localparam logic signed [CALC_W-1:0] POLL_MIN =
    -(CALC_W'(1) <<< (POLL_W - 1));

  // configuration
  logic [2:0] baud_div_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & ~cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {29'd0, baud_div_r};

  // input register
  logic        s1_valid_r;
  func_t       s1_func_r;
  logic [7:0]  s1_wr_data_r;
  logic [15:0] s1_cyc_r;
  logic        s1_rx_present_r;
  logic [7:0]  s1_rx_byte_r;
  logic        s1_cts_r;
  logic        s1_dsr_r;

  logic        s1_adv;
  logic        in_xfer;

  assign in_stall = s1_valid_r & out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign s1_adv   = s1_valid_r & ~(out_valid & out_stall);

  // block state
  phase_t                     phase_r,  phase_nxt;
  logic [7:0]                 mode_r,   mode_nxt;
  logic [7:0]                 cmd_r,    cmd_nxt;
  status_t                    status_r, status_nxt;
  logic [1:0]                 rf_r,     rf_nxt;
  logic [7:0]                 rx_hold_r, rx_hold_nxt;
  logic [7:0]                 tx_hold_r, tx_hold_nxt;
  logic                       tx_busy_r, tx_busy_nxt;
  txcnt_t                     tx_cnt_r, tx_cnt_nxt;
  logic signed [POLL_W-1:0]   poll_r,   poll_nxt;
  logic                       cts_r,    cts_nxt;
  logic                       dsr_r,    dsr_nxt;

  logic signed [CALC_W-1:0]   poll_sub;
  logic signed [CALC_W-1:0]   poll_sum;
  logic [7:0]                 rd_nxt;
  logic                       txv_nxt;
  logic [7:0]                 txb_nxt;
  logic                       taken_nxt;

  always_comb begin
    phase_nxt   = phase_r;
    mode_nxt    = mode_r;
    cmd_nxt     = cmd_r;
    status_nxt  = status_r;
    rf_nxt      = rf_r;
    rx_hold_nxt = rx_hold_r;
    tx_hold_nxt = tx_hold_r;
    tx_busy_nxt = tx_busy_r;
    tx_cnt_nxt  = tx_cnt_r;
    poll_nxt    = poll_r;
    cts_nxt     = cts_r;
    dsr_nxt     = dsr_r;
    rd_nxt      = 8'd0;
    txv_nxt     = 1'b0;
    txb_nxt     = 8'd0;
    taken_nxt   = 1'b0;
    poll_sub    = CALC_W'(poll_r) - CALC_W'(s1_cyc_r);
    poll_sum    = poll_sub + POLL_ADD;

    case (s1_func_r)
      FN_DATA_RD: begin
        status_nxt[SB_RXRDY] = 1'b0;
        rd_nxt               = rx_hold_r;
      end
      FN_DATA_WR: begin
        tx_hold_nxt          = s1_wr_data_r;
        tx_busy_nxt          = 1'b1;
        status_nxt[SB_TXRDY] = 1'b0;
        status_nxt[SB_TXE]   = 1'b0;
        tx_cnt_nxt           = char_period(baud_div_r, rf_r);
      end
      FN_STAT_RD: begin
        rd_nxt                = {dsr_r, status_r};
        status_nxt[SB_SYNDET] = 1'b0;
      end
      FN_CTRL_WR: begin
        case (phase_r)
          PH_MODE: begin
            mode_nxt = s1_wr_data_r;
            if (s1_wr_data_r[1:0] == 2'd0) begin
              rf_nxt    = RF_X1;
              phase_nxt = PH_SYNC1;
            end else begin
              rf_nxt    = s1_wr_data_r[1:0];
              phase_nxt = PH_CMD;
            end
          end
          PH_SYNC1: phase_nxt = mode_r[7] ? PH_CMD : PH_SYNC2;
          PH_SYNC2: phase_nxt = PH_CMD;
          default: begin
            if (s1_wr_data_r[6]) begin
              // internal reset
              phase_nxt   = PH_MODE;
              mode_nxt    = 8'd0;
              cmd_nxt     = 8'd0;
              status_nxt  = STATUS_RESET;
              rf_nxt      = RF_X1;
              tx_busy_nxt = 1'b0;
              tx_cnt_nxt  = '0;
              poll_nxt    = POLL_RST;
            end else begin
              cmd_nxt = s1_wr_data_r;
              if (s1_wr_data_r[4]) begin
                status_nxt[SB_PE] = 1'b0;
                status_nxt[SB_OE] = 1'b0;
                status_nxt[SB_FE] = 1'b0;
              end
            end
          end
        endcase
      end
      FN_TICK: begin
        if (tx_busy_r) begin
          if (TXCNT_W'(s1_cyc_r) >= tx_cnt_r) begin
            tx_cnt_nxt           = '0;
            tx_busy_nxt          = 1'b0;
            txv_nxt              = 1'b1;
            txb_nxt              = tx_hold_r;
            status_nxt[SB_TXE]   = 1'b1;
            status_nxt[SB_TXRDY] = 1'b1;
          end else begin
            tx_cnt_nxt = tx_cnt_r - TXCNT_W'(s1_cyc_r);
          end
        end
        if (poll_sub <= 0) begin
          poll_nxt = (poll_sum < POLL_MIN) ? POLL_W'(POLL_MIN) : POLL_W'(poll_sum);
          cts_nxt  = s1_cts_r;
          dsr_nxt  = s1_dsr_r;
          if (cmd_r[2] && s1_rx_present_r) begin
            if (status_r[SB_RXRDY]) status_nxt[SB_OE] = 1'b1;
            rx_hold_nxt          = s1_rx_byte_r;
            status_nxt[SB_RXRDY] = 1'b1;
            taken_nxt            = 1'b1;
          end
        end else begin
          poll_nxt = POLL_W'(poll_sub);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baud_div_r <= 3'd0;
    end else if (cfg_wr) begin
      baud_div_r <= cfg_pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r       <= in_func;
      s1_wr_data_r    <= in_wr_data;
      s1_cyc_r        <= in_tick_cycles;
      s1_rx_present_r <= in_rx_present;
      s1_rx_byte_r    <= in_rx_byte;
      s1_cts_r        <= in_cts_in;
      s1_dsr_r        <= in_dsr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MODE;
      mode_r    <= 8'd0;
      cmd_r     <= 8'd0;
      status_r  <= STATUS_RESET;
      rf_r      <= RF_X1;
      rx_hold_r <= 8'd0;
      tx_hold_r <= 8'd0;
      tx_busy_r <= 1'b0;
      tx_cnt_r  <= '0;
      poll_r    <= POLL_RST;
      cts_r     <= 1'b1;
      dsr_r     <= 1'b1;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      mode_r    <= mode_nxt;
      cmd_r     <= cmd_nxt;
      status_r  <= status_nxt;
      rf_r      <= rf_nxt;
      rx_hold_r <= rx_hold_nxt;
      tx_hold_r <= tx_hold_nxt;
      tx_busy_r <= tx_busy_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
      poll_r    <= poll_nxt;
      cts_r     <= cts_nxt;
      dsr_r     <= dsr_nxt;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_read_data <= rd_nxt;
      out_tx_valid  <= txv_nxt;
      out_tx_byte   <= txb_nxt;
      out_txrdy     <= cmd_nxt[0] & cts_nxt & status_nxt[SB_TXRDY];
      out_rxrdy     <= status_nxt[SB_RXRDY];
      out_rx_taken  <= taken_nxt;
      out_rts_out   <= ~cmd_nxt[5];
      out_dtr_out   <= ~cmd_nxt[1];
    end
  end

  assign out_valid = out_valid_r;

endmodule
